@@ rtl/rmt_pkg.sv @@
// Shared types and constants for the running mode tracker.
package rmt_pkg;

  localparam int NUM_BINS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 16;
  localparam int VALUE_W        = 8;
  localparam int TIE_W          = 9;
  localparam int OUT_DEPTH      = 4;

  localparam logic [VALUE_W-1:0] MAX_VALUE_RST = 8'd255;
  localparam logic [TIE_W-1:0]   TIE_MAX       = 9'd511;
  localparam logic [TIE_W-1:0]   TIE_ONE       = 9'd1;

  typedef struct packed {
    logic [VALUE_W-1:0] mode_value;
    logic [TIE_W-1:0]   tie_count;
    logic               range_error;
  } result_t;

  typedef struct packed {
    logic busy;     // an item sits in the update stage
    logic last;     // that item will push a result
  } core_status_t;

endpackage

@@ rtl/rmt_if.sv @@
// Stream interfaces for sample input and result output.
interface rmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic       first;
  logic       last;

  modport source (output valid, output value, output first, output last, input ready);
  modport sink   (input valid, input value, input first, input last, output ready);
endinterface

interface rmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mode_value;
  logic [8:0] tie_count;
  logic       range_error;

  modport source (output valid, output mode_value, output tie_count, output range_error,
                  input ready);
  modport sink   (input valid, input mode_value, input tie_count, input range_error,
                  output ready);
endinterface

@@ rtl/rmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rmt_core.sv @@
// Histogram read-modify-write stage with forwarding and mode tracking.
module rmt_core #(
  parameter int NUM_BINS   = rmt_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = rmt_pkg::COUNT_BITS_DEF,
  localparam int AW = $clog2(NUM_BINS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [rmt_pkg::VALUE_W-1:0]   in_value,
  input  logic                          in_first,
  input  logic                          in_last,
  input  logic [rmt_pkg::VALUE_W-1:0]   max_value,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [COUNT_BITS-1:0]         ram_rdata,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [COUNT_BITS-1:0]         ram_wdata,
  output logic                          push,
  output rmt_pkg::result_t              push_data,
  output rmt_pkg::core_status_t         status
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // update stage
  logic                          s1_valid;
  logic [rmt_pkg::VALUE_W-1:0]   s1_value;
  logic                          s1_first;
  logic                          s1_last;
  logic                          s1_ok;

  // last write, for an item read in the same cycle it was written
  logic                          fwd_valid;
  logic [AW-1:0]                 fwd_addr;
  logic [COUNT_BITS-1:0]         fwd_data;

  logic [NUM_BINS-1:0]           bin_valid;

  logic [rmt_pkg::VALUE_W-1:0]   mode_reg;
  logic [COUNT_BITS-1:0]         mode_freq;
  logic [rmt_pkg::TIE_W-1:0]     tie_reg;
  logic                          error_seen;

  logic [AW-1:0]                 idx;
  logic [rmt_pkg::VALUE_W-1:0]   cur_mode;
  logic [COUNT_BITS-1:0]         cur_freq;
  logic [rmt_pkg::TIE_W-1:0]     cur_tie;
  logic                          cur_err;
  logic [COUNT_BITS-1:0]         base;
  logic [COUNT_BITS-1:0]         cnt1;
  logic                          bump;
  logic [rmt_pkg::VALUE_W-1:0]   mode_next;
  logic [COUNT_BITS-1:0]         freq_next;
  logic [rmt_pkg::TIE_W-1:0]     tie_next;
  logic                          err_next;
  logic [NUM_BINS-1:0]           set_mask;

  assign ram_raddr = AW'(in_value);

  always_comb begin
    idx      = AW'(s1_value);
    cur_mode = s1_first ? '0 : mode_reg;
    cur_freq = s1_first ? '0 : mode_freq;
    cur_tie  = s1_first ? rmt_pkg::TIE_ONE : tie_reg;
    cur_err  = s1_first ? 1'b0 : error_seen;

    // a first item sees an empty histogram
    priority if (s1_first) begin
      base = '0;
    end else if (fwd_valid && (fwd_addr == idx)) begin
      base = fwd_data;
    end else if (bin_valid[idx]) begin
      base = ram_rdata;
    end else begin
      base = '0;
    end

    bump = s1_valid && s1_ok && (base != COUNT_MAX);
    cnt1 = base + COUNT_BITS'(1);

    mode_next = cur_mode;
    freq_next = cur_freq;
    tie_next  = cur_tie;
    if (bump) begin
      if ((s1_value == cur_mode) || (cnt1 > cur_freq)) begin
        mode_next = s1_value;
        freq_next = cnt1;
        tie_next  = rmt_pkg::TIE_ONE;
      end else if ((cnt1 == cur_freq) && (cur_tie != rmt_pkg::TIE_MAX)) begin
        tie_next  = cur_tie + rmt_pkg::TIE_ONE;
      end
    end
    err_next = cur_err | (s1_valid && !s1_ok);
    set_mask = bump ? (NUM_BINS'(1) << idx) : '0;
  end

  assign ram_we    = bump;
  assign ram_waddr = idx;
  assign ram_wdata = cnt1;

  assign push                  = s1_valid && s1_last;
  assign push_data.mode_value  = mode_next;
  assign push_data.tie_count   = tie_next;
  assign push_data.range_error = err_next;

  assign status.busy = s1_valid;
  assign status.last = s1_valid && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
      bin_valid  <= '0;
      mode_reg   <= '0;
      mode_freq  <= '0;
      tie_reg    <= rmt_pkg::TIE_ONE;
      error_seen <= 1'b0;
    end else begin
      s1_valid  <= in_fire;
      fwd_valid <= bump;
      if (s1_valid) begin
        bin_valid  <= (s1_first ? '0 : bin_valid) | set_mask;
        mode_reg   <= mode_next;
        mode_freq  <= freq_next;
        tie_reg    <= tie_next;
        error_seen <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_value <= in_value;
      s1_first <= in_first;
      s1_last  <= in_last;
      s1_ok    <= (in_value <= max_value) && (32'(in_value) < 32'(NUM_BINS));
    end
    fwd_addr <= idx;
    fwd_data <= cnt1;
  end

endmodule

@@ rtl/rmt_fifo.sv @@
// Small register FIFO that holds results until the consumer takes them.
module rmt_fifo #(
  parameter int DEPTH = rmt_pkg::OUT_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rmt_pkg::result_t     push_data,
  output logic [CW-1:0]        fill,
  rmt_out_if.source            result
);

  rmt_pkg::result_t entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             pop;

  assign pop                = result.valid && result.ready;
  assign result.valid       = (fill != '0);
  assign result.mode_value  = entries[rptr].mode_value;
  assign result.tie_count   = entries[rptr].tie_count;
  assign result.range_error = entries[rptr].range_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      fill <= fill + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

@@ rtl/running_mode_tracker.sv @@
// A last-flagged item passes the update stage register, then enters the result
// FIFO. Throughput: one item per cycle; the bin count lives in a RAM, read in the
// accept cycle and written back in the next, with the previous write forwarded.
// Input stalls only when the four-entry result FIFO could overflow. Reset (rst,
// synchronous) clears every bin, the mode state, the FIFO and sets max_value to
// 255; there is no clearing pass, the block is ready the next cycle.
module running_mode_tracker #(
  parameter int NUM_BINS   = rmt_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = rmt_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rmt_pkg::VALUE_W-1:0] cfg_wr_data,
  rmt_in_if.sink                      sample,
  rmt_out_if.source                   result
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int CW = $clog2(rmt_pkg::OUT_DEPTH + 1);

  logic [rmt_pkg::VALUE_W-1:0] max_value;
  logic                        in_fire;
  logic [AW-1:0]               ram_raddr;
  logic [COUNT_BITS-1:0]       ram_rdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [COUNT_BITS-1:0]       ram_wdata;
  logic                        push;
  rmt_pkg::result_t            push_data;
  rmt_pkg::core_status_t       status;
  logic [CW-1:0]               fill;
  logic [CW:0]                 pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= rmt_pkg::MAX_VALUE_RST;
    end else if (cfg_wr_en) begin
      max_value <= cfg_wr_data;
    end
  end

  // reserve a FIFO slot for a last-flagged item in the update stage
  assign pending      = (CW + 1)'(fill) + (CW + 1)'(status.last);
  assign sample.ready = (pending < (CW + 1)'(rmt_pkg::OUT_DEPTH));
  assign in_fire      = sample.valid && sample.ready;

  rmt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rmt_core #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_value  (sample.value),
    .in_first  (sample.first),
    .in_last   (sample.last),
    .max_value (max_value),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_data (push_data),
    .status    (status)
  );

  rmt_fifo #(
    .DEPTH (rmt_pkg::OUT_DEPTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .fill      (fill),
    .result    (result)
  );

endmodule

@@ rtl/rmt_checker.sv @@
// Port-level checks for the running mode tracker, bound to the top level.
module rmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] out_tie_count
);

  // no result can be pending right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // the tie count never drops to zero
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (out_tie_count != 9'd0))
    else $error("tie count of zero");

  // after a last item is accepted, out_valid is high once it has passed the update stage and reached the FIFO
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> ##1 out_valid)
    else $error("missing result after last item");

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind running_mode_tracker rmt_checker u_rmt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (sample.valid),
  .in_ready      (sample.ready),
  .in_last       (sample.last),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_tie_count (result.tie_count)
);

@@ test/tb_running_mode_tracker.sv @@
// Self-checking testbench for the running mode tracker: directed and random sequences.
`timescale 1ns / 1ps

module tb_running_mode_tracker;

  localparam int CLK_HALF = 4;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned RANDOM_PHASE_ITEMS = 250;
  localparam logic [15:0] COUNT_SAT = 16'hFFFF;

  typedef struct {
    logic [rmt_pkg::VALUE_W-1:0] value;
    logic                        first;
    logic                        last;
    int unsigned                 gap;
  } sample_item_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [rmt_pkg::VALUE_W-1:0] cfg_wr_data;

  rmt_in_if  in_bus ();
  rmt_out_if out_bus ();

  running_mode_tracker dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (in_bus),
    .result      (out_bus)
  );

  // Histogram and mode state kept alongside the block
  logic [15:0]                 bin_tally [rmt_pkg::NUM_BINS_DEF];
  logic [rmt_pkg::VALUE_W-1:0] cur_mode;
  logic [15:0]                 cur_freq;
  logic [rmt_pkg::TIE_W-1:0]   cur_ties;
  logic                        saw_reject;
  logic [rmt_pkg::VALUE_W-1:0] limit_value;

  rmt_pkg::result_t modes_due [$];
  sample_item_t     pending_samples [$];
  sample_item_t     next_sample;
  rmt_pkg::result_t want;

  bit          calm;
  bit          in_fire;
  bit          out_fire;
  int unsigned wait_cnt;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned fault_count;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned settings_used;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void restart_tally();
    foreach (bin_tally[i]) bin_tally[i] = '0;
    cur_mode   = '0;
    cur_freq   = '0;
    cur_ties   = rmt_pkg::TIE_ONE;
    saw_reject = 1'b0;
  endfunction

  function automatic void tally_sample(logic [rmt_pkg::VALUE_W-1:0] v, logic first,
                                       logic last);
    logic [15:0]      c;
    rmt_pkg::result_t r;
    if (first) restart_tally();
    if (v > limit_value) begin
      saw_reject = 1'b1;
    end else if (bin_tally[v] < COUNT_SAT) begin
      c = bin_tally[v] + 16'd1;
      bin_tally[v] = c;
      if (v == cur_mode || c > cur_freq) begin
        cur_mode = v;
        cur_freq = c;
        cur_ties = rmt_pkg::TIE_ONE;
      end else if (c == cur_freq && cur_ties < rmt_pkg::TIE_MAX) begin
        cur_ties = cur_ties + rmt_pkg::TIE_ONE;
      end
    end
    if (last) begin
      r.mode_value  = cur_mode;
      r.tie_count   = cur_ties;
      r.range_error = saw_reject;
      modes_due.push_back(r);
    end
  endfunction

  function automatic int unsigned draw_idle();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic void queue_sample(logic [rmt_pkg::VALUE_W-1:0] v, logic first,
                                       logic last);
    sample_item_t s;
    s.value = v;
    s.first = first;
    s.last  = last;
    s.gap   = draw_idle();
    pending_samples.push_back(s);
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Input side: predict on every accepted item
  always @(posedge clk) begin
    in_fire <= !rst && in_bus.valid && in_bus.ready;
    if (!rst && in_bus.valid && in_bus.ready) begin
      tally_sample(in_bus.value, in_bus.first, in_bus.last);
      items_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      wait_cnt = 0;
    end else if (!in_bus.valid || in_fire) begin
      if (pending_samples.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (wait_cnt < pending_samples[0].gap) begin
        wait_cnt++;
        in_bus.valid <= 1'b0;
      end else begin
        next_sample = pending_samples.pop_front();
        wait_cnt = 0;
        in_bus.valid <= 1'b1;
        in_bus.value <= next_sample.value;
        in_bus.first <= next_sample.first;
        in_bus.last  <= next_sample.last;
      end
    end
  end

  // Output side: stall while a result waits, then check it
  always @(negedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      stall_left = draw_idle();
    end else begin
      if (out_fire) stall_left = draw_idle();
      else if (stall_left > 0 && out_bus.valid) stall_left--;
      out_bus.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    out_fire <= !rst && out_bus.valid && out_bus.ready;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (modes_due.size() == 0) begin
        note_fault($sformatf("Unexpected result: mode %0d ties %0d range_error %0b",
                             out_bus.mode_value, out_bus.tie_count, out_bus.range_error));
      end else begin
        want = modes_due.pop_front();
        if (out_bus.mode_value !== want.mode_value || out_bus.tie_count !== want.tie_count ||
            out_bus.range_error !== want.range_error)
          note_fault($sformatf({"Result %0d mismatch: expected mode %0d ties %0d ",
                                "range_error %0b, got mode %0d ties %0d range_error %0b"},
                               results_seen, want.mode_value, want.tie_count,
                               want.range_error, out_bus.mode_value, out_bus.tie_count,
                               out_bus.range_error));
        results_seen++;
      end
    end
  end

  // Hold until every queued item is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_bus.valid || modes_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [rmt_pkg::VALUE_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_value = v;
    settings_used++;
  endtask

  task automatic queue_random_phase(int unsigned n_items);
    int unsigned                 added;
    int unsigned                 len;
    int unsigned                 base;
    int unsigned                 span;
    int unsigned                 kind;
    logic [rmt_pkg::VALUE_W-1:0] v;
    added = 0;
    while (added < n_items) begin
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, limit_value);
      span = $urandom_range(0, 7);
      kind = $urandom_range(0, 9);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) v = 8'($urandom_range(0, 255));
        else v = 8'(base + $urandom_range(0, span));
        // mostly well-formed sequences; some carry on without a first flag, some are noise
        if (kind == 0)
          queue_sample(v, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        else if (kind == 1)
          queue_sample(v, 1'b0, i == len - 1);
        else
          queue_sample(v, i == 0, i == len - 1);
      end
      added += len;
    end
  endtask

  initial begin
    logic [rmt_pkg::VALUE_W-1:0] limits [8];
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    in_bus.first  = 1'b0;
    in_bus.last   = 1'b0;
    out_bus.ready = 1'b0;
    calm          = 1'b0;
    restart_tally();
    limit_value   = rmt_pkg::MAX_VALUE_RST;
    settings_used = 1;
    limits = '{8'd255, 8'd0, 8'd1, 8'd254, 8'd0, 8'd128, 8'd0, 8'd255};
    limits[4] = 8'($urandom_range(2, 253));
    limits[6] = 8'($urandom_range(2, 253));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limit: accumulate without a first flag, ties, mode handover
    queue_sample(8'd0,   1'b0, 1'b0);
    queue_sample(8'd255, 1'b0, 1'b1);
    queue_sample(8'd7,   1'b1, 1'b1);
    queue_sample(8'd5,   1'b1, 1'b0);
    queue_sample(8'd9,   1'b0, 1'b0);
    queue_sample(8'd9,   1'b0, 1'b0);
    queue_sample(8'd5,   1'b0, 1'b0);
    queue_sample(8'd5,   1'b0, 1'b1);
    queue_sample(8'd1,   1'b1, 1'b0);
    queue_sample(8'd2,   1'b0, 1'b0);
    queue_sample(8'd3,   1'b0, 1'b1);
    queue_sample(8'd2,   1'b0, 1'b1);
    queue_sample(8'd3,   1'b0, 1'b1);
    drain();

    // rejected values, rejected first element, empty sequence
    write_limit(8'd0);
    queue_sample(8'd0,   1'b1, 1'b0);
    queue_sample(8'd1,   1'b0, 1'b0);
    queue_sample(8'd255, 1'b0, 1'b1);
    queue_sample(8'd200, 1'b1, 1'b0);
    queue_sample(8'd0,   1'b0, 1'b1);
    queue_sample(8'd9,   1'b1, 1'b1);
    drain();

    write_limit(8'd100);
    queue_sample(8'd150, 1'b1, 1'b0);
    queue_sample(8'd42,  1'b0, 1'b1);
    queue_sample(8'd101, 1'b1, 1'b1);
    queue_sample(8'd100, 1'b1, 1'b1);
    drain();

    foreach (limits[p]) begin
      write_limit(limits[p]);
      calm = (p == 2 || p == 5);
      queue_random_phase(RANDOM_PHASE_ITEMS);
      drain();
    end

    repeat (8) @(posedge clk);
    while (modes_due.size() != 0) begin
      want = modes_due.pop_front();
      note_fault($sformatf("Missing result: mode %0d ties %0d range_error %0b",
                           want.mode_value, want.tie_count, want.range_error));
    end

    $display("Run covered %0d input items and %0d checked results across %0d limit settings",
             items_taken, results_seen, settings_used);
    $display("including rejected values, empty sequences and sequences without a first flag");
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d faults found", fault_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rmt_pkg.sv
rtl/rmt_if.sv
rtl/rmt_ram.sv
rtl/rmt_core.sv
rtl/rmt_fifo.sv
rtl/running_mode_tracker.sv
rtl/rmt_checker.sv
test/tb_running_mode_tracker.sv
